[src/sacl_pkg.sv]
// Package for the set-associative LRU cache: sizes, register indexes and the
// row and lookup-result types shared by the submodules. No dependencies.
`default_nettype none

package sacl_pkg;

    localparam int MAX_WAYS  = 8;
    localparam int MAX_SETS  = 64;
    localparam int ADDR_BITS = 16;

    localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_BITS    = WAY_BITS;
    localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);
    localparam int SET_BITS     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_CNT_BITS = $clog2(MAX_SETS + 1);
    localparam int STEP_BITS    = $clog2(ADDR_BITS + 1);

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int WAYS_CFG_BITS = 4;
    localparam int SETS_CFG_BITS = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_WAYS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SETS_IN_USE = 2'd1;

    localparam logic [WAYS_CFG_BITS-1:0] WAYS_RESET = WAYS_CFG_BITS'(MAX_WAYS);
    localparam logic [SETS_CFG_BITS-1:0] SETS_RESET = SETS_CFG_BITS'(MAX_SETS);

    localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(MAX_WAYS - 1);

    // One set: every way's tag, valid bit and age.
    typedef struct packed {
        logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
    } row_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  way;
        logic                 evicted;
        logic [ADDR_BITS-1:0] evicted_address;
    } lookup_res_t;

endpackage

`default_nettype wire

[src/set_assoc_cache_lru.sv]
// Top level of the set-associative cache with LRU replacement: handshakes,
// configuration registers and the access sequencer. Depends on sacl_pkg,
// sacl_mod_unit, sacl_row_ram and sacl_way_logic.
//
//   channel | signals                                   | transaction
//   --------+-------------------------------------------+---------------------------
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//   in      | in_valid, in_ready, address               | one access
//   out     | out_valid, out_ready, hit .. evicted_addr | one access result
//
// An access runs from acceptance to a result through the serial remainder unit
// (one address bit per cycle), the set read, and the update and write-back of
// the row.
// A new access is taken only once the previous one has written its row back.
// The result register holds a result while out_ready is low; the next access
// may then run, and stalls before write-back until the register is free.
// Reset empties every set at once through the per-row written flags.
`default_nettype none

module set_assoc_cache_lru
    import sacl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [ADDR_BITS-1:0]     address,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          hit,
    output logic [SET_BITS-1:0]           set_index,
    output logic [WAY_BITS-1:0]           way_used,
    output logic                          evicted,
    output logic [ADDR_BITS-1:0]          evicted_address
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIV    = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [WAYS_CFG_BITS-1:0] ways_cfg_reg;
    logic [SETS_CFG_BITS-1:0] sets_cfg_reg;
    logic [WAY_CNT_BITS-1:0]  eff_ways;
    logic [SET_CNT_BITS-1:0]  eff_sets;
    logic [WAY_CNT_BITS-1:0]  nways_reg;
    logic [ADDR_BITS-1:0]     addr_reg;
    logic [SET_BITS-1:0]      set_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg;
    logic [SET_BITS-1:0]      set_out_reg;
    logic [WAY_BITS-1:0]      way_reg;
    logic                     evicted_reg;
    logic [ADDR_BITS-1:0]     evicted_address_reg;

    logic                     in_fire;
    logic                     mod_done;
    logic [SET_BITS-1:0]      mod_rem;
    logic                     wr_en;
    row_t                     rd_row;
    row_t                     new_row;
    lookup_res_t              res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // Out-of-range register values are clamped: zero to one, and values above the sizes built to those sizes.
    always_comb
    begin
        priority if (ways_cfg_reg == '0)
            eff_ways = WAY_CNT_BITS'(1);
        else if (ways_cfg_reg > WAYS_CFG_BITS'(MAX_WAYS))
            eff_ways = WAY_CNT_BITS'(MAX_WAYS);
        else
            eff_ways = WAY_CNT_BITS'(ways_cfg_reg);

        priority if (sets_cfg_reg == '0)
            eff_sets = SET_CNT_BITS'(1);
        else if (sets_cfg_reg > SETS_CFG_BITS'(MAX_SETS))
            eff_sets = SET_CNT_BITS'(MAX_SETS);
        else
            eff_sets = SET_CNT_BITS'(sets_cfg_reg);
    end

    sacl_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .dividend  (address),
        .divisor   (eff_sets),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    sacl_row_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mod_done),
        .rd_addr (mod_rem),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_row  (new_row)
    );

    sacl_way_logic u_way (
        .row_in  (rd_row),
        .addr    (addr_reg),
        .nways   (nways_reg),
        .row_out (new_row),
        .res     (res)
    );

    assign wr_en = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (mod_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (wr_en)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ways_cfg_reg  <= WAYS_RESET;
            sets_cfg_reg  <= SETS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WAYS_IN_USE)
                    ways_cfg_reg <= cfg_data[WAYS_CFG_BITS-1:0];
                else if (cfg_index == REG_SETS_IN_USE)
                    sets_cfg_reg <= cfg_data[SETS_CFG_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg  <= address;
            nways_reg <= eff_ways;
        end
        if (mod_done)
            set_reg <= mod_rem;
        if (wr_en)
        begin
            hit_reg             <= res.hit;
            set_out_reg         <= set_reg;
            way_reg             <= res.way;
            evicted_reg         <= res.evicted;
            evicted_address_reg <= res.evicted_address;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign set_index       = set_out_reg;
    assign way_used        = way_reg;
    assign evicted         = evicted_reg;
    assign evicted_address = evicted_address_reg;

`ifndef SYNTHESIS
    // The remainder unit only finishes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_DIV)
        else $error("remainder finished outside the divide phase");

    // A write-back always leaves a result waiting and the block ready again.
    a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> out_valid_reg && state_reg == S_IDLE)
        else $error("write-back did not produce a result");

    // A lookup never both hits and evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> !(res.hit && res.evicted))
        else $error("lookup reports a hit and an eviction");

    // Without an eviction the evicted address reads as zero.
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !evicted_reg |-> evicted_address_reg == '0)
        else $error("evicted address set without an eviction");
`endif

endmodule

`default_nettype wire

[src/sacl_mod_unit.sv]
// Serial remainder unit: address modulo the set count, one dividend bit per
// cycle by restoring division. Depends on sacl_pkg.
`default_nettype none

module sacl_mod_unit
    import sacl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [ADDR_BITS-1:0]    dividend,
    input  wire logic [SET_CNT_BITS-1:0] divisor,
    output logic                         done,
    output logic [SET_BITS-1:0]          remainder
);

    logic [STEP_BITS-1:0]    cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [ADDR_BITS-1:0]    dq_reg, dq_next;
    logic [SET_BITS-1:0]     rem_reg, rem_next;
    logic [SET_CNT_BITS-1:0] div_reg, div_next;
    logic [SET_BITS:0]       trial;

    // The partial remainder stays below the divisor, so one more bit fits.
    assign trial = {rem_reg, dq_reg[ADDR_BITS-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next = STEP_BITS'(ADDR_BITS);
            dq_next  = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            dq_next  = {dq_reg[ADDR_BITS-2:0], 1'b0};
            if ((SET_BITS+1)'(trial) >= (SET_BITS+1)'(div_reg))
                rem_next = SET_BITS'(trial - (SET_BITS+1)'(div_reg));
            else
                rem_next = SET_BITS'(trial);
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[src/sacl_row_ram.sv]
// Set memory: one row per set holding tags, valid bits and ages, with a
// registered read and a per-row written flag cleared by reset. Depends on sacl_pkg.
`default_nettype none

module sacl_row_ram
    import sacl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [SET_BITS-1:0] rd_addr,
    output row_t                     rd_row,
    input  wire logic                wr_en,
    input  wire logic [SET_BITS-1:0] wr_addr,
    input  wire row_t                wr_row
);

    row_t                mem [MAX_SETS];
    logic [MAX_SETS-1:0] written_reg;
    row_t                rd_data_reg;
    logic                rd_fresh_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_fresh_reg <= written_reg[rd_addr];
        end
    end

    // A row never written reads as empty: no valid ways, all ages zero.
    assign rd_row = rd_fresh_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[src/sacl_way_logic.sv]
// Lookup and update of one set: tag compare, empty-way and victim search,
// and the LRU age update of the row written back. Depends on sacl_pkg.
`default_nettype none

module sacl_way_logic
    import sacl_pkg::*;
(
    input  wire row_t                    row_in,
    input  wire logic [ADDR_BITS-1:0]    addr,
    input  wire logic [WAY_CNT_BITS-1:0] nways,
    output row_t                         row_out,
    output lookup_res_t                  res
);

    logic [MAX_WAYS-1:0]     in_use;
    logic                    hit_found;
    logic [WAY_BITS-1:0]     hit_way;
    logic                    empty_found;
    logic [WAY_BITS-1:0]     empty_way;
    logic [RANK_BITS-1:0]    best;
    logic [WAY_BITS-1:0]     victim;
    logic [WAY_BITS-1:0]     way;
    logic [WAY_CNT_BITS-1:0] limit;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
            in_use[i] = (nways > WAY_CNT_BITS'(i));

        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        best        = '0;
        victim      = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && row_in.valid[i] && row_in.tag[i] == addr && !hit_found)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_BITS'(i);
            end
            if (in_use[i] && !row_in.valid[i] && !empty_found)
            begin
                empty_found = 1'b1;
                empty_way   = WAY_BITS'(i);
            end
            // Oldest way wins; on equal ages the lower way is kept.
            if (in_use[i] && (i == 0 || row_in.rank[i] > best))
            begin
                best   = row_in.rank[i];
                victim = WAY_BITS'(i);
            end
        end

        priority if (hit_found)
        begin
            way   = hit_way;
            limit = WAY_CNT_BITS'(row_in.rank[hit_way]);
        end
        else if (empty_found)
        begin
            way   = empty_way;
            limit = WAY_CNT_BITS'(MAX_WAYS);
        end
        else
        begin
            way   = victim;
            limit = WAY_CNT_BITS'(best);
        end

        row_out = row_in;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && row_in.valid[i] && WAY_BITS'(i) != way
                && WAY_CNT_BITS'(row_in.rank[i]) < limit && row_in.rank[i] < RANK_MAX)
                row_out.rank[i] = row_in.rank[i] + 1'b1;
        end
        row_out.rank[way] = '0;
        if (!hit_found)
        begin
            row_out.tag[way]   = addr;
            row_out.valid[way] = 1'b1;
        end

        res.hit             = hit_found;
        res.way             = way;
        res.evicted         = !hit_found && !empty_found;
        res.evicted_address = (!hit_found && !empty_found) ? row_in.tag[victim] : '0;
    end

endmodule

`default_nettype wire
